@@ src/esc_pkg.sv @@
// esc_pkg: sizes, types and codes shared by the expert slot cache modules
// no dependencies
package esc_pkg;

  localparam int NUM_LAYERS  = 64;
  localparam int NUM_EXPERTS = 256;
  localparam int NUM_SLOTS   = 64;
  localparam int MAX_GROUP   = 32;

  localparam int EW     = 10;
  localparam int EXW    = $clog2(NUM_EXPERTS);
  localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SCW    = $clog2(NUM_SLOTS + 1);
  localparam int IW     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int FW     = $clog2(MAX_GROUP + 1);
  localparam int GAW    = IW + 1;
  localparam int GDEPTH = 2 ** GAW;
  localparam int CDEPTH = NUM_LAYERS * NUM_SLOTS;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int AGEW   = 48;
  localparam int CNTW   = 32;
  localparam int CEW    = 1 + EXW + AGEW;

  localparam logic [1:0] REG_LAYER_COUNT  = 2'd0;
  localparam logic [1:0] REG_EXPERT_COUNT = 2'd1;
  localparam logic [1:0] REG_SLOT_COUNT   = 2'd2;

  localparam logic CMD_DEMAND = 1'b0;

  typedef enum logic [2:0] {
    KIND_COPY      = 3'd0,
    KIND_DONE_OK   = 3'd1,
    KIND_DONE_FAIL = 3'd2,
    KIND_IGNORED   = 3'd3,
    KIND_OVERFLOW  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_ELEM, ST_SCAN, ST_DEC, ST_COPY, ST_DONE
  } back_state_t;

  typedef struct packed {
    logic          ovf;
    logic          cmd;
    logic [6:0]    layer;
    logic [FW-1:0] n;
    logic          bank;
  } desc_t;

  typedef struct packed {
    logic clearing;
    logic rel;
    logic rel_bank;
  } back_status_t;

  typedef struct packed {
    logic [7:0]     layers;
    logic [9:0]     experts;
    logic [SCW-1:0] slots;
  } cfg_eff_t;

endpackage

@@ src/esc_ram.sv @@
// esc_ram: generic single write port ram with registered read
// no dependencies
module esc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ src/esc_front.sv @@
// esc_front: gathers items into group buffers, builds pin sets, queues groups
// depends on esc_pkg
module esc_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_clear,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_command,
  input  logic [6:0]                             in_layer,
  input  logic signed [esc_pkg::EW-1:0]          in_expert,
  input  logic                                   in_last,
  output logic                                   gb_we,
  output logic [esc_pkg::GAW-1:0]                gb_waddr,
  output logic [esc_pkg::EW-1:0]                 gb_wdata,
  output logic [1:0][esc_pkg::NUM_EXPERTS-1:0]   pins,
  output logic                                   q_valid,
  output esc_pkg::desc_t                         q_head,
  input  logic                                   q_pop,
  input  esc_pkg::back_status_t                  st
);

  logic [esc_pkg::FW-1:0]                fill_r, fill_nxt;
  logic                                  wb_r, wb_nxt;
  logic [1:0]                            busy_r, busy_nxt;
  logic [1:0][esc_pkg::NUM_EXPERTS-1:0]  pin_r, pin_nxt;
  esc_pkg::desc_t                        fifo_r [2];
  esc_pkg::desc_t                        fifo_nxt [2];
  logic                                  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]                            cnt_r, cnt_nxt;
  logic                                  acc, fits, pin_ok, push;
  esc_pkg::desc_t                        d;

  assign in_ready = !st.clearing && (cnt_r != 2'd2) && !busy_r[wb_r];
  assign acc      = in_valid && in_ready;
  assign fits     = fill_r < esc_pkg::FW'(esc_pkg::MAX_GROUP);
  assign pin_ok   = !in_expert[esc_pkg::EW-1] &&
                    ($unsigned(in_expert) < esc_pkg::EW'(esc_pkg::NUM_EXPERTS));
  assign push     = acc && (in_last || !fits);
  assign gb_we    = acc && fits;
  assign gb_waddr = {wb_r, fill_r[esc_pkg::IW-1:0]};
  assign gb_wdata = in_expert;
  assign pins     = pin_r;
  assign q_valid  = cnt_r != 2'd0;
  assign q_head   = fifo_r[rp_r];

  always_comb begin
    fill_nxt = fill_r;
    wb_nxt   = wb_r;
    busy_nxt = busy_r;
    pin_nxt  = pin_r;
    fifo_nxt = fifo_r;
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    cnt_nxt  = cnt_r;
    d.ovf    = !in_last;
    d.cmd    = in_command;
    d.layer  = in_layer;
    d.n      = fill_r + esc_pkg::FW'(fits);
    d.bank   = wb_r;
    if (st.rel) begin
      busy_nxt[st.rel_bank] = 1'b0;
      pin_nxt[st.rel_bank]  = '0;
    end
    if (acc) begin
      if (fits) begin
        fill_nxt = fill_r + 1'b1;
        if (pin_ok) begin
          pin_nxt[wb_r][in_expert[esc_pkg::EXW-1:0]] = 1'b1;
        end
      end
      if (in_last) begin
        fill_nxt       = '0;
        busy_nxt[wb_r] = 1'b1;
        wb_nxt         = !wb_r;
      end
    end
    if (push) begin
      fifo_nxt[wp_r] = d;
      wp_nxt         = !wp_r;
    end
    if (q_pop) begin
      rp_nxt = !rp_r;
    end
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
    if (cfg_clear) begin
      fill_nxt      = '0;
      pin_nxt[wb_r] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      wb_r   <= 1'b0;
      busy_r <= '0;
      pin_r  <= '0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      wb_r   <= wb_nxt;
      busy_r <= busy_nxt;
      pin_r  <= pin_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fifo_r <= fifo_nxt;
  end

endmodule

@@ src/esc_back.sv @@
// esc_back: runs queued groups against the slot table, scans for hit and victim
// depends on esc_pkg and esc_ram
module esc_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_clear,
  input  esc_pkg::cfg_eff_t                     eff,
  input  logic                                  q_valid,
  input  esc_pkg::desc_t                        q_head,
  output logic                                  q_pop,
  input  logic [1:0][esc_pkg::NUM_EXPERTS-1:0]  pins,
  output logic [esc_pkg::GAW-1:0]               gb_raddr,
  input  logic [esc_pkg::EW-1:0]                gb_rdata,
  output esc_pkg::back_status_t                 st,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            out_kind,
  output logic [7:0]                            out_expert_out,
  output logic [5:0]                            out_slot_out,
  output logic [31:0]                           out_hit_total,
  output logic [31:0]                           out_miss_total,
  output logic                                  out_end_of_run
);

  esc_pkg::back_state_t          state_r, state_nxt;
  esc_pkg::desc_t                desc_r, desc_nxt;
  esc_pkg::kind_t                kind_r, kind_nxt;
  logic [esc_pkg::FW-1:0]        i_r, i_nxt;
  logic [esc_pkg::EXW-1:0]       ue_r, ue_nxt;
  logic [esc_pkg::CAW-1:0]       base_r, base_nxt;
  logic [esc_pkg::CAW-1:0]       clr_r, clr_nxt;
  logic [esc_pkg::AGEW-1:0]      clk_r, clk_nxt;
  logic [esc_pkg::CNTW-1:0]      hit_r, hit_nxt, miss_r, miss_nxt;
  logic [esc_pkg::SCW-1:0]       sc_r, sc_nxt;
  logic                          pend_r, pend_nxt;
  logic [esc_pkg::SW-1:0]        ridx_r, ridx_nxt;
  logic                          hitf_r, hitf_nxt, empf_r, empf_nxt, bestf_r, bestf_nxt;
  logic [esc_pkg::SW-1:0]        hidx_r, hidx_nxt, eidx_r, eidx_nxt;
  logic [esc_pkg::SW-1:0]        bidx_r, bidx_nxt, sel_r, sel_nxt;
  logic [esc_pkg::AGEW-1:0]      bage_r, bage_nxt;
  logic                          ov_r, ov_nxt;
  logic [2:0]                    okind_r, okind_nxt;
  logic [7:0]                    oexp_r, oexp_nxt;
  logic [5:0]                    oslot_r, oslot_nxt;
  logic [31:0]                   ohit_r, ohit_nxt, omiss_r, omiss_nxt;
  logic                          oeor_r, oeor_nxt;

  logic                          c_we;
  logic [esc_pkg::CAW-1:0]       c_waddr, c_raddr;
  logic [esc_pkg::CEW-1:0]       c_wdata, c_rdata;
  logic                          rv, demand, out_free, disabled, e_ok;
  logic [esc_pkg::EXW-1:0]       rex;
  logic [esc_pkg::AGEW-1:0]      rage;
  logic [esc_pkg::SW-1:0]        wslot;

  esc_ram #(.W(esc_pkg::CEW), .D(2 ** esc_pkg::CAW)) u_cache (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  assign rv       = c_rdata[esc_pkg::CEW-1];
  assign rex      = c_rdata[esc_pkg::AGEW +: esc_pkg::EXW];
  assign rage     = c_rdata[esc_pkg::AGEW-1:0];
  assign demand   = desc_r.cmd == esc_pkg::CMD_DEMAND;
  assign out_free = !ov_r || out_ready;
  assign c_raddr  = base_r + esc_pkg::CAW'(sc_r[esc_pkg::SW-1:0]);
  assign gb_raddr = {desc_r.bank, i_r[esc_pkg::IW-1:0]};
  assign disabled = (eff.layers == 8'd0) || (eff.slots == '0) ||
                    ({1'b0, q_head.layer} >= eff.layers);
  assign e_ok     = !gb_rdata[esc_pkg::EW-1] &&
                    ({1'b0, gb_rdata[esc_pkg::EW-2:0]} < eff.experts);

  assign out_valid      = ov_r;
  assign out_kind       = okind_r;
  assign out_expert_out = oexp_r;
  assign out_slot_out   = oslot_r;
  assign out_hit_total  = ohit_r;
  assign out_miss_total = omiss_r;
  assign out_end_of_run = oeor_r;

  always_comb begin
    state_nxt = state_r;
    desc_nxt  = desc_r;
    kind_nxt  = kind_r;
    i_nxt     = i_r;
    ue_nxt    = ue_r;
    base_nxt  = base_r;
    clr_nxt   = clr_r;
    clk_nxt   = clk_r;
    hit_nxt   = hit_r;
    miss_nxt  = miss_r;
    sc_nxt    = sc_r;
    pend_nxt  = pend_r;
    ridx_nxt  = ridx_r;
    hitf_nxt  = hitf_r;
    empf_nxt  = empf_r;
    bestf_nxt = bestf_r;
    hidx_nxt  = hidx_r;
    eidx_nxt  = eidx_r;
    bidx_nxt  = bidx_r;
    bage_nxt  = bage_r;
    sel_nxt   = sel_r;
    ov_nxt    = ov_r && !out_ready;
    okind_nxt = okind_r;
    oexp_nxt  = oexp_r;
    oslot_nxt = oslot_r;
    ohit_nxt  = ohit_r;
    omiss_nxt = omiss_r;
    oeor_nxt  = oeor_r;
    q_pop     = 1'b0;
    c_we      = 1'b0;
    wslot     = hidx_r;
    c_waddr   = base_r + esc_pkg::CAW'(wslot);
    c_wdata   = {1'b1, ue_r, clk_r};
    st.clearing = state_r == esc_pkg::ST_CLEAR;
    st.rel      = 1'b0;
    st.rel_bank = desc_r.bank;

    case (state_r)
      esc_pkg::ST_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_r;
        c_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == esc_pkg::CAW'(2 ** esc_pkg::CAW - 1)) begin
          state_nxt = esc_pkg::ST_IDLE;
        end
      end
      esc_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          desc_nxt = q_head;
          i_nxt    = '0;
          base_nxt = esc_pkg::CAW'(32'(q_head.layer) * esc_pkg::NUM_SLOTS);
          if (q_head.ovf) begin
            kind_nxt  = esc_pkg::KIND_OVERFLOW;
            state_nxt = esc_pkg::ST_DONE;
          end else if (disabled) begin
            kind_nxt  = esc_pkg::KIND_IGNORED;
            state_nxt = esc_pkg::ST_DONE;
          end else begin
            clk_nxt   = clk_r + 1'b1;
            kind_nxt  = esc_pkg::KIND_DONE_OK;
            state_nxt = esc_pkg::ST_READ;
          end
        end
      end
      esc_pkg::ST_READ: begin
        if (i_r == desc_r.n) begin
          state_nxt = esc_pkg::ST_DONE;
        end else begin
          state_nxt = esc_pkg::ST_ELEM;
        end
      end
      esc_pkg::ST_ELEM: begin
        if (e_ok) begin
          ue_nxt    = gb_rdata[esc_pkg::EXW-1:0];
          sc_nxt    = '0;
          pend_nxt  = 1'b0;
          hitf_nxt  = 1'b0;
          empf_nxt  = 1'b0;
          bestf_nxt = 1'b0;
          state_nxt = esc_pkg::ST_SCAN;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = esc_pkg::ST_READ;
        end
      end
      esc_pkg::ST_SCAN: begin
        pend_nxt = 1'b0;
        if (sc_r < eff.slots) begin
          pend_nxt = 1'b1;
          ridx_nxt = sc_r[esc_pkg::SW-1:0];
          sc_nxt   = sc_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = esc_pkg::ST_DEC;
        end
        if (pend_r) begin
          if (!rv) begin
            if (!empf_r) begin
              empf_nxt = 1'b1;
              eidx_nxt = ridx_r;
            end
          end else if (rex == ue_r) begin
            hitf_nxt = 1'b1;
            hidx_nxt = ridx_r;
          end else if (!pins[desc_r.bank][rex] && (!bestf_r || rage < bage_r)) begin
            bestf_nxt = 1'b1;
            bidx_nxt  = ridx_r;
            bage_nxt  = rage;
          end
        end
      end
      esc_pkg::ST_DEC: begin
        if (hitf_r) begin
          if (demand && hit_r != '1) begin
            hit_nxt = hit_r + 1'b1;
          end
          c_we      = 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = esc_pkg::ST_READ;
        end else begin
          if (demand && miss_r != '1) begin
            miss_nxt = miss_r + 1'b1;
          end
          if (empf_r || bestf_r) begin
            wslot     = empf_r ? eidx_r : bidx_r;
            c_waddr   = base_r + esc_pkg::CAW'(wslot);
            c_we      = 1'b1;
            sel_nxt   = wslot;
            state_nxt = esc_pkg::ST_COPY;
          end else begin
            kind_nxt  = demand ? esc_pkg::KIND_DONE_FAIL : esc_pkg::KIND_DONE_OK;
            state_nxt = esc_pkg::ST_DONE;
          end
        end
      end
      esc_pkg::ST_COPY: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = esc_pkg::KIND_COPY;
          oexp_nxt  = 8'(ue_r);
          oslot_nxt = 6'(sel_r);
          ohit_nxt  = '0;
          omiss_nxt = '0;
          oeor_nxt  = 1'b0;
          i_nxt     = i_r + 1'b1;
          state_nxt = esc_pkg::ST_READ;
        end
      end
      esc_pkg::ST_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = kind_r;
          oexp_nxt  = '0;
          oslot_nxt = '0;
          if (kind_r == esc_pkg::KIND_OVERFLOW) begin
            ohit_nxt  = '0;
            omiss_nxt = '0;
            oeor_nxt  = 1'b0;
          end else begin
            ohit_nxt  = hit_r;
            omiss_nxt = miss_r;
            oeor_nxt  = 1'b1;
            st.rel    = 1'b1;
          end
          state_nxt = esc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = esc_pkg::ST_CLEAR;
      end
    endcase

    if (cfg_clear) begin
      state_nxt = esc_pkg::ST_CLEAR;
      clr_nxt   = '0;
      clk_nxt   = '0;
      hit_nxt   = '0;
      miss_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esc_pkg::ST_CLEAR;
      clr_r   <= '0;
      clk_r   <= '0;
      hit_r   <= '0;
      miss_r  <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      clk_r   <= clk_nxt;
      hit_r   <= hit_nxt;
      miss_r  <= miss_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r  <= desc_nxt;
    kind_r  <= kind_nxt;
    i_r     <= i_nxt;
    ue_r    <= ue_nxt;
    base_r  <= base_nxt;
    sc_r    <= sc_nxt;
    ridx_r  <= ridx_nxt;
    hitf_r  <= hitf_nxt;
    empf_r  <= empf_nxt;
    bestf_r <= bestf_nxt;
    hidx_r  <= hidx_nxt;
    eidx_r  <= eidx_nxt;
    bidx_r  <= bidx_nxt;
    bage_r  <= bage_nxt;
    sel_r   <= sel_nxt;
    okind_r <= okind_nxt;
    oexp_r  <= oexp_nxt;
    oslot_r <= oslot_nxt;
    ohit_r  <= ohit_nxt;
    omiss_r <= omiss_nxt;
    oeor_r  <= oeor_nxt;
  end

endmodule

@@ src/pinned_lru_expert_slot_cache.sv @@
// pinned_lru_expert_slot_cache: top level with register port, front, group ram, back
// depends on esc_pkg, esc_ram, esc_front, esc_back
//
// Items are gathered into a group (up to MAX_GROUP per group, two groups in
// flight) and a closed group is run against the slot table of its layer. Each
// valid expert of the group goes through a read and a decode step, a scan of
// slot_count slots with the read pipe drained after it, and a decision step,
// with one more step when a copy order goes out. A skipped id passes through
// the read and decode steps only. The scan through the slot table memory sets
// the rate at which groups are handled. Results leave through one output
// register, so a stalled receiver holds the back end, and the input stalls
// once both group buffers or the two-entry group queue are full. After reset
// and after every write to the layer, expert or slot count register the slot
// table is swept empty, all NUM_LAYERS * NUM_SLOTS entries (4096), during
// which no item is taken.
module pinned_lru_expert_slot_cache (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [6:0]                    in_layer,
  input  logic signed [9:0]             in_expert,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_kind,
  output logic [7:0]                    out_expert_out,
  output logic [5:0]                    out_slot_out,
  output logic [31:0]                   out_hit_total,
  output logic [31:0]                   out_miss_total,
  output logic                          out_end_of_run
);

  logic [6:0]                            lc_r, lc_nxt;
  logic [8:0]                            ec_r, ec_nxt;
  logic [6:0]                            sc_r, sc_nxt;
  logic                                  wr, cfg_clear;
  logic [9:0]                            ee, es;
  esc_pkg::cfg_eff_t                     eff;
  logic                                  gb_we;
  logic [esc_pkg::GAW-1:0]               gb_waddr, gb_raddr;
  logic [esc_pkg::EW-1:0]                gb_wdata, gb_rdata;
  logic [1:0][esc_pkg::NUM_EXPERTS-1:0]  pins;
  logic                                  q_valid, q_pop;
  esc_pkg::desc_t                        q_head;
  esc_pkg::back_status_t                 st;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    lc_nxt    = lc_r;
    ec_nxt    = ec_r;
    sc_nxt    = sc_r;
    cfg_clear = 1'b0;
    prdata    = '0;
    case (paddr[3:2])
      esc_pkg::REG_LAYER_COUNT: begin
        prdata = 32'(lc_r);
        if (wr) begin
          lc_nxt    = pwdata[6:0];
          cfg_clear = 1'b1;
        end
      end
      esc_pkg::REG_EXPERT_COUNT: begin
        prdata = 32'(ec_r);
        if (wr) begin
          ec_nxt    = pwdata[8:0];
          cfg_clear = 1'b1;
        end
      end
      esc_pkg::REG_SLOT_COUNT: begin
        prdata = 32'(sc_r);
        if (wr) begin
          sc_nxt    = pwdata[6:0];
          cfg_clear = 1'b1;
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r <= '0;
      ec_r <= '0;
      sc_r <= '0;
    end else begin
      lc_r <= lc_nxt;
      ec_r <= ec_nxt;
      sc_r <= sc_nxt;
    end
  end

  always_comb begin
    ee = ({1'b0, ec_r} > 10'(esc_pkg::NUM_EXPERTS)) ? 10'(esc_pkg::NUM_EXPERTS)
                                                      : {1'b0, ec_r};
    es = {3'b0, sc_r};
    if (es > ee) begin
      es = ee;
    end
    if (es > 10'(esc_pkg::NUM_SLOTS)) begin
      es = 10'(esc_pkg::NUM_SLOTS);
    end
    eff.experts = ee;
    eff.slots   = esc_pkg::SCW'(es);
    eff.layers  = ({1'b0, lc_r} > 8'(esc_pkg::NUM_LAYERS)) ? 8'(esc_pkg::NUM_LAYERS)
                                                           : {1'b0, lc_r};
  end

  esc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_clear  (cfg_clear),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_layer   (in_layer),
    .in_expert  (in_expert),
    .in_last    (in_last),
    .gb_we      (gb_we),
    .gb_waddr   (gb_waddr),
    .gb_wdata   (gb_wdata),
    .pins       (pins),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .st         (st)
  );

  esc_ram #(.W(esc_pkg::EW), .D(esc_pkg::GDEPTH)) u_group (
    .clk   (clk),
    .we    (gb_we),
    .waddr (gb_waddr),
    .wdata (gb_wdata),
    .raddr (gb_raddr),
    .rdata (gb_rdata)
  );

  esc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_clear      (cfg_clear),
    .eff            (eff),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .pins           (pins),
    .gb_raddr       (gb_raddr),
    .gb_rdata       (gb_rdata),
    .st             (st),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_expert_out (out_expert_out),
    .out_slot_out   (out_slot_out),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total),
    .out_end_of_run (out_end_of_run)
  );

endmodule
